// ----- src/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants for the trapezoid profile calculator.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int ACCEL_BITS    = 24;
	localparam int MIN_RATE_BITS = 16;
	localparam logic [MIN_RATE_BITS-1:0] MIN_RATE_RESET = 16'd120;

endpackage

// ----- src/tpc_div.sv -----
// ----------------------------------------------------------------------------
// tpc_div
// Pipelined restoring divider, one quotient bit per stage. Flags quotients
// that do not fit Q_BITS as saturated.
// ----------------------------------------------------------------------------
module tpc_div #(
	parameter int NUM_W  = 50,
	parameter int DEN_W  = 26,
	parameter int Q_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              out_vld,
	output logic [Q_BITS-1:0] quo,
	output logic              rem_nz,
	output logic              sat
);

	localparam int SW = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

	logic              vld_s [Q_BITS+1];
	logic [DEN_W-1:0]  rem_s [Q_BITS+1];
	logic [Q_BITS-1:0] low_s [Q_BITS+1];
	logic [Q_BITS-1:0] quo_s [Q_BITS+1];
	logic [DEN_W-1:0]  den_s [Q_BITS+1];
	logic              sat_s [Q_BITS+1];

	logic [SW-1:0] num_w;
	logic [SW-1:0] den_w;

	assign num_w = SW'(num);
	assign den_w = SW'({den, {Q_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DEN_W'(num_w >> Q_BITS);
		low_s[0] <= num[Q_BITS-1:0];
		quo_s[0] <= '0;
		den_s[0] <= den;
		sat_s[0] <= (num_w >= den_w);
	end

	for (genvar k = 1; k <= Q_BITS; k++) begin : g_stage
		logic [DEN_W:0] t;
		logic           ge;

		assign t  = {rem_s[k-1], low_s[k-1][Q_BITS-1]};
		assign ge = (t >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DEN_W'(t - {1'b0, den_s[k-1]}) : DEN_W'(t);
			low_s[k] <= {low_s[k-1][Q_BITS-2:0], 1'b0};
			quo_s[k] <= {quo_s[k-1][Q_BITS-2:0], ge};
			den_s[k] <= den_s[k-1];
			sat_s[k] <= sat_s[k-1];
		end
	end

	assign out_vld = vld_s[Q_BITS];
	assign quo     = quo_s[Q_BITS];
	assign rem_nz  = (rem_s[Q_BITS] != '0);
	assign sat     = sat_s[Q_BITS];

endmodule

// ----- src/trapezoid_profile_calc_unit.sv -----
// ----------------------------------------------------------------------------
// trapezoid_profile_calc_unit
// Trapezoid velocity profile of one stepper move: entry and exit rates and
// the step indices where acceleration ends and deceleration begins.
// ----------------------------------------------------------------------------
// A move is taken on any cycle with start high; busy is always low, so one
// move can enter every clock. Its result appears on done after four front
// stages, the divider's input stage and its COUNT_BITS one-bit stages, and
// two closing stages, in the order the moves entered. The result cannot be
// held off: it stands for one cycle only.
// Write min_step_rate only while no move is in flight.
module trapezoid_profile_calc_unit #(
	parameter int RATE_BITS     = 20,
	parameter int COUNT_BITS    = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [tpc_pkg::MIN_RATE_BITS-1:0]      cfg_wdata,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [RATE_BITS-1:0]                   cruise_rate,
	input  logic [FRACTION_BITS:0]                 entry_scale,
	input  logic [FRACTION_BITS:0]                 exit_scale,
	input  logic [COUNT_BITS-1:0]                  step_count,
	input  logic [tpc_pkg::ACCEL_BITS-1:0]         accel_rate,
	input  logic                                   move_busy,
	output logic                                   done,
	output logic [COUNT_BITS-1:0]                  accel_end,
	output logic [COUNT_BITS-1:0]                  decel_start,
	output logic [RATE_BITS-1:0]                   entry_rate,
	output logic [RATE_BITS-1:0]                   exit_rate,
	output logic                                   written
);

	localparam int A     = tpc_pkg::ACCEL_BITS;
	localparam int MRW   = tpc_pkg::MIN_RATE_BITS;
	localparam int R     = RATE_BITS;
	localparam int C     = COUNT_BITS;
	localparam int F     = FRACTION_BITS;
	localparam int PW    = R + F + 1;
	localparam int NUM_W = ((2 * R > A + 1 + C) ? 2 * R : A + 1 + C) + 1;
	localparam int DEN_W = A + 2;
	localparam int LW    = (MRW > R) ? MRW : R;

	typedef struct packed {
		logic [C-1:0] cnt;
		logic [R-1:0] ent;
		logic [R-1:0] ext;
		logic         mbusy;
		logic         azero;
	} side_t;

	logic [MRW-1:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= tpc_pkg::MIN_RATE_RESET;
		end else if (cfg_we) begin
			min_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// Stage 1: clamp factors, multiply
	logic [F:0] ef_c, xf_c;
	assign ef_c = (entry_scale > (F+1)'(1) << F) ? (F+1)'(1) << F : entry_scale;
	assign xf_c = (exit_scale > (F+1)'(1) << F) ? (F+1)'(1) << F : exit_scale;

	logic            v_s1;
	logic [PW-1:0]   pe_s1, px_s1;
	logic [2*R-1:0]  nsq_s1;
	logic [A+C-1:0]  ac_s1;
	logic [C-1:0]    cnt_s1;
	logic [A-1:0]    acc_s1;
	logic            mb_s1;

	always_ff @(posedge clk) begin
		pe_s1  <= PW'(cruise_rate) * PW'(ef_c);
		px_s1  <= PW'(cruise_rate) * PW'(xf_c);
		nsq_s1 <= (2*R)'(cruise_rate) * (2*R)'(cruise_rate);
		ac_s1  <= (A+C)'(accel_rate) * (A+C)'(step_count);
		cnt_s1 <= step_count;
		acc_s1 <= accel_rate;
		mb_s1  <= move_busy;
	end

	// Stage 2: round up, raise to minimum
	logic [LW-1:0] lo_w;
	logic [R-1:0]  lo;
	logic [R-1:0]  re, rx, re_c, rx_c;

	assign lo_w = (LW'(min_q) > LW'({R{1'b1}})) ? LW'({R{1'b1}}) : LW'(min_q);
	assign lo   = R'(lo_w);
	assign re   = R'(pe_s1 >> F) + R'(pe_s1[F-1:0] != '0);
	assign rx   = R'(px_s1 >> F) + R'(px_s1[F-1:0] != '0);
	assign re_c = (re < lo) ? lo : re;
	assign rx_c = (rx < lo) ? lo : rx;

	logic           v_s2;
	logic [R-1:0]   ent_s2, ext_s2;
	logic [2*R-1:0] nsq_s2;
	logic [A+C-1:0] ac_s2;
	logic [C-1:0]   cnt_s2;
	logic [A-1:0]   acc_s2;
	logic           mb_s2;

	always_ff @(posedge clk) begin
		ent_s2 <= re_c;
		ext_s2 <= rx_c;
		nsq_s2 <= nsq_s1;
		ac_s2  <= ac_s1;
		cnt_s2 <= cnt_s1;
		acc_s2 <= acc_s1;
		mb_s2  <= mb_s1;
	end

	// Stage 3: square the rates
	logic           v_s3;
	logic [R-1:0]   ent_s3, ext_s3;
	logic [2*R-1:0] nsq_s3, esq_s3, xsq_s3;
	logic [A+C-1:0] ac_s3;
	logic [C-1:0]   cnt_s3;
	logic [A-1:0]   acc_s3;
	logic           mb_s3;

	always_ff @(posedge clk) begin
		esq_s3 <= (2*R)'(ent_s2) * (2*R)'(ent_s2);
		xsq_s3 <= (2*R)'(ext_s2) * (2*R)'(ext_s2);
		ent_s3 <= ent_s2;
		ext_s3 <= ext_s2;
		nsq_s3 <= nsq_s2;
		ac_s3  <= ac_s2;
		cnt_s3 <= cnt_s2;
		acc_s3 <= acc_s2;
		mb_s3  <= mb_s2;
	end

	// Stage 4: dividends, negative differences drop to zero
	logic [NUM_W-1:0] top;
	assign top = NUM_W'({ac_s3, 1'b0}) + NUM_W'(xsq_s3);

	logic             v_s4;
	logic [NUM_W-1:0] ma_s4, md_s4, mi_s4;
	logic [DEN_W-1:0] d2_s4, d4_s4;
	side_t            sd_s4;

	always_ff @(posedge clk) begin
		ma_s4 <= (nsq_s3 >= esq_s3) ? NUM_W'(nsq_s3 - esq_s3) : '0;
		md_s4 <= (nsq_s3 >= xsq_s3) ? NUM_W'(nsq_s3 - xsq_s3) : '0;
		mi_s4 <= (top >= NUM_W'(esq_s3)) ? top - NUM_W'(esq_s3) : '0;
		d2_s4 <= DEN_W'({acc_s3, 1'b0});
		d4_s4 <= DEN_W'({acc_s3, 2'b00});
		sd_s4 <= '{cnt: cnt_s3, ent: ent_s3, ext: ext_s3, mbusy: mb_s3,
		           azero: (acc_s3 == '0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Divider lanes
	logic         va, vd, vi;
	logic [C-1:0] qa, qd, qi;
	logic         na, nd, ni;
	logic         sa, sdv, si;

	tpc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_BITS(C)) u_div_acc (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s4), .num(ma_s4), .den(d2_s4),
		.out_vld(va), .quo(qa), .rem_nz(na), .sat(sa)
	);

	tpc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_BITS(C)) u_div_dec (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s4), .num(md_s4), .den(d2_s4),
		.out_vld(vd), .quo(qd), .rem_nz(nd), .sat(sdv)
	);

	tpc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_BITS(C)) u_div_int (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s4), .num(mi_s4), .den(d4_s4),
		.out_vld(vi), .quo(qi), .rem_nz(ni), .sat(si)
	);

	// Hold sideband alongside the divider stages
	side_t sd_s [C+1];

	always_ff @(posedge clk) begin
		sd_s[0] <= sd_s4;
		for (int k = 1; k <= C; k++) begin
			sd_s[k] <= sd_s[k-1];
		end
	end

	side_t sdo;
	assign sdo = sd_s[C];

	// Stage 5: round up the accel and crossing distances, saturate all three
	logic [C:0] qa_up, qi_up;
	assign qa_up = (C+1)'(qa) + (C+1)'(na);
	assign qi_up = (C+1)'(qi) + (C+1)'(ni);

	logic         v_s5;
	logic [C-1:0] as_s5, ds_s5, is_s5;
	side_t        sd_s5;

	always_ff @(posedge clk) begin
		as_s5 <= sdo.azero ? '0 :
		         (sa || qa_up > (C+1)'(sdo.cnt)) ? sdo.cnt : C'(qa_up);
		ds_s5 <= sdo.azero ? '0 : (sdv || qd > sdo.cnt) ? sdo.cnt : qd;
		is_s5 <= (si || qi_up > (C+1)'(sdo.cnt)) ? sdo.cnt : C'(qi_up);
		sd_s5 <= sdo;
	end

	// Stage 6: plateau test, output register
	logic [C:0] sum;
	assign sum = (C+1)'(as_s5) + (C+1)'(ds_s5);

	always_ff @(posedge clk) begin
		if (sum > (C+1)'(sd_s5.cnt)) begin
			accel_end   <= is_s5;
			decel_start <= is_s5;
		end else begin
			accel_end   <= as_s5;
			decel_start <= sd_s5.cnt - ds_s5;
		end
		entry_rate <= sd_s5.ent;
		exit_rate  <= sd_s5.ext;
		written    <= !sd_s5.mbusy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s5 <= va;
			done <= v_s5;
		end
	end

`ifndef SYNTH
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		va == vd && va == vi)
		else $error("divider lanes out of step");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> accel_end <= decel_start)
		else $error("acceleration ends after deceleration begins");

	a_entry_min: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entry_rate >= lo && exit_rate >= lo)
		else $error("rate below minimum");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trapezoid_profile_calc_unit. Moves are sent through
// the start/busy handshake while an internal profile predictor works out the
// expected rates and step indices. Every done strobe is compared field by
// field with the oldest pending profile. The run covers directed corners,
// several min_step_rate settings and random moves under varying sender gaps.
// ----------------------------------------------------------------------------
module tb;

	localparam int RATE_BITS     = 20;
	localparam int COUNT_BITS    = 24;
	localparam int FRACTION_BITS = 16;
	localparam int ACCEL_BITS    = tpc_pkg::ACCEL_BITS;
	localparam int MIN_RATE_BITS = tpc_pkg::MIN_RATE_BITS;
	localparam int DRAIN_CYCLES  = COUNT_BITS + 16;

	typedef struct packed {
		logic [RATE_BITS-1:0]     nominal;
		logic [FRACTION_BITS:0]   efac;
		logic [FRACTION_BITS:0]   xfac;
		logic [COUNT_BITS-1:0]    count;
		logic [ACCEL_BITS-1:0]    accel;
		logic                     mbusy;
	} move_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] acc_until;
		logic [COUNT_BITS-1:0] dec_after;
		logic [RATE_BITS-1:0]  entry;
		logic [RATE_BITS-1:0]  exitr;
		logic                  wr;
	} profile_t;

	logic clk, arst_n, cfg_we, start, busy, done, move_busy, written;
	logic [MIN_RATE_BITS-1:0] cfg_wdata;
	logic [RATE_BITS-1:0] cruise_rate, entry_rate, exit_rate;
	logic [FRACTION_BITS:0] entry_scale, exit_scale;
	logic [COUNT_BITS-1:0] step_count, accel_end, decel_start;
	logic [ACCEL_BITS-1:0] accel_rate;

	profile_t pending_profiles[$];
	logic [MIN_RATE_BITS-1:0] min_rate;
	int gap_pct, mismatches, profiles_checked, moves_sent;

	trapezoid_profile_calc_unit #(
		.RATE_BITS(RATE_BITS), .COUNT_BITS(COUNT_BITS), .FRACTION_BITS(FRACTION_BITS)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .cruise_rate(cruise_rate),
		.entry_scale(entry_scale), .exit_scale(exit_scale),
		.step_count(step_count), .accel_rate(accel_rate), .move_busy(move_busy),
		.done(done), .accel_end(accel_end),
		.decel_start(decel_start), .entry_rate(entry_rate),
		.exit_rate(exit_rate), .written(written)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] scale_rate(logic [RATE_BITS-1:0] nominal,
			logic [FRACTION_BITS:0] fac);
		logic [63:0] f, p, r;
		f = (fac > (1 << FRACTION_BITS)) ? (64'd1 << FRACTION_BITS) : 64'(fac);
		p = 64'(nominal) * f;
		r = p >> FRACTION_BITS;
		if (p[FRACTION_BITS-1:0] != 0)
			r = r + 1;
		if (r < 64'(min_rate))
			r = 64'(min_rate);
		return r;
	endfunction

	function automatic logic [63:0] sat_quot(logic [63:0] x, logic [63:0] y,
			logic [63:0] d, bit up, logic [63:0] cap);
		logic [63:0] m, q;
		if (x < y)
			return 0;
		m = x - y;
		q = m / d;
		if (up && (m % d) != 0)
			q = q + 1;
		return (q > cap) ? cap : q;
	endfunction

	function automatic profile_t plan_profile(move_t m);
		profile_t p;
		logic [63:0] entry, exitr, nsq, esq, xsq, a, cnt, acc, dec, top;
		entry = scale_rate(m.nominal, m.efac);
		exitr = scale_rate(m.nominal, m.xfac);
		nsq = 64'(m.nominal) * 64'(m.nominal);
		esq = entry * entry;
		xsq = exitr * exitr;
		a = 64'(m.accel);
		cnt = 64'(m.count);
		acc = 0;
		dec = 0;
		if (a != 0) begin
			acc = sat_quot(nsq, esq, 2 * a, 1'b1, cnt);
			dec = sat_quot(nsq, xsq, 2 * a, 1'b0, cnt);
		end
		if (acc + dec > cnt) begin
			top = 2 * a * cnt + xsq;
			p.acc_until = COUNT_BITS'(sat_quot(top, esq, 4 * a, 1'b1, cnt));
			p.dec_after = p.acc_until;
		end else begin
			p.acc_until = COUNT_BITS'(acc);
			p.dec_after = COUNT_BITS'(cnt - dec);
		end
		p.entry = RATE_BITS'(entry);
		p.exitr = RATE_BITS'(exitr);
		p.wr = ~m.mbusy;
		return p;
	endfunction

	task automatic send_move(move_t m);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cruise_rate <= m.nominal;
		entry_scale <= m.efac;
		exit_scale <= m.xfac;
		step_count <= m.count;
		accel_rate <= m.accel;
		move_busy <= m.mbusy;
		pending_profiles.push_back(plan_profile(m));
		moves_sent++;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_profiles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_rate(logic [MIN_RATE_BITS-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_rate = value;
	endtask

	function automatic logic [31:0] rand_bits(int width);
		logic [31:0] v;
		v = $urandom() & 32'((64'd1 << width) - 1);
		if ($urandom_range(2) != 0)
			v = v >> $urandom_range(width - 1);
		return v;
	endfunction

	function automatic move_t rand_move();
		move_t m;
		m.nominal = RATE_BITS'(rand_bits(RATE_BITS));
		case ($urandom_range(4))
			0: m.efac = (FRACTION_BITS+1)'(1 << FRACTION_BITS);
			1: m.efac = (FRACTION_BITS+1)'($urandom_range((1 << (FRACTION_BITS + 1)) - 1));
			default: m.efac = (FRACTION_BITS+1)'($urandom_range(1 << FRACTION_BITS));
		endcase
		case ($urandom_range(4))
			0: m.xfac = (FRACTION_BITS+1)'(1 << FRACTION_BITS);
			1: m.xfac = (FRACTION_BITS+1)'($urandom_range((1 << (FRACTION_BITS + 1)) - 1));
			default: m.xfac = (FRACTION_BITS+1)'($urandom_range(1 << FRACTION_BITS));
		endcase
		m.count = COUNT_BITS'(rand_bits(COUNT_BITS));
		m.accel = ($urandom_range(15) == 0) ? '0 : ACCEL_BITS'(rand_bits(ACCEL_BITS));
		m.mbusy = ($urandom_range(4) == 0);
		return m;
	endfunction

	function automatic move_t mk(int nom, int ef, int xf, int cnt, int acc, bit mb);
		move_t m;
		m.nominal = RATE_BITS'(nom);
		m.efac = (FRACTION_BITS+1)'(ef);
		m.xfac = (FRACTION_BITS+1)'(xf);
		m.count = COUNT_BITS'(cnt);
		m.accel = ACCEL_BITS'(acc);
		m.mbusy = mb;
		return m;
	endfunction

	always @(posedge clk) begin
		profile_t exp_p, got;
		if (arst_n && done) begin
			got = '{accel_end, decel_start, entry_rate, exit_rate, written};
			if (pending_profiles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %p", got);
			end else begin
				exp_p = pending_profiles.pop_front();
				profiles_checked++;
				if (got !== exp_p) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, actual %p", exp_p, got);
				end
			end
		end
	end

	task automatic test_directed;
		gap_pct = 30;
		send_move(mk(0, 0, 0, 0, 0, 0));
		send_move(mk(1048575, 65536, 65536, 16777215, 16777215, 0));
		send_move(mk(1048575, 0, 0, 16777215, 1, 0));
		send_move(mk(1048575, 131071, 131071, 1000, 5000, 0));
		send_move(mk(40000, 16384, 32768, 100000, 0, 0));
		send_move(mk(40000, 16384, 32768, 100000, 8000, 1));
		send_move(mk(100, 65536, 65536, 500, 300, 0));
		send_move(mk(50000, 100, 200, 10, 2000, 0));
		send_move(mk(50000, 65535, 1, 16777215, 16777215, 1));
		send_move(mk(1048575, 1, 65535, 0, 16777215, 0));
		send_move(mk(12345, 65537, 3, 7, 1, 0));
		send_move(mk(999999, 43690, 21845, 12345678, 777, 0));
		send_move(mk(1, 65536, 65536, 1, 1, 1));
	endtask

	task automatic test_min_rate;
		logic [MIN_RATE_BITS-1:0] rates[4];
		rates = '{16'd0, 16'hFFFF, 16'd1, 16'h8000};
		foreach (rates[i]) begin
			write_min_rate(rates[i]);
			gap_pct = 30;
			send_move(mk(0, 0, 0, 50, 10, 0));
			send_move(mk(70000, 65536, 1000, 20000, 3000, 0));
			repeat (20) send_move(rand_move());
		end
		write_min_rate(tpc_pkg::MIN_RATE_RESET);
	endtask

	task automatic test_random(int pct, int n);
		gap_pct = pct;
		repeat (n) send_move(rand_move());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		cruise_rate = '0;
		entry_scale = '0;
		exit_scale = '0;
		step_count = '0;
		accel_rate = '0;
		move_busy = 1'b0;
		min_rate = tpc_pkg::MIN_RATE_RESET;
		mismatches = 0;
		profiles_checked = 0;
		moves_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_min_rate();
		test_random(30, 200);
		write_min_rate(MIN_RATE_BITS'($urandom_range(2000)));
		test_random(64, 200);
		write_min_rate(tpc_pkg::MIN_RATE_RESET);
		test_random(0, 200);
		drain();
		$display("Checked %0d of %0d moves: directed corners, several min_step_rate values,",
			profiles_checked, moves_sent);
		$display("random moves with 30%%, 64%% and no sender gaps; %0d mismatches", mismatches);
		if (mismatches == 0 && pending_profiles.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/tpc_pkg.sv
src/tpc_div.sv
src/trapezoid_profile_calc_unit.sv
tb/tb.sv
